// ===== sv/c3c_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the clamped 3x3 convolution block.
// No dependencies; every other file in sv/ imports this package.
package c3c_pkg;

    typedef logic signed [5:0]  pix_t;
    typedef logic [9:0]         coord_t;
    typedef logic signed [3:0]  coef_t;
    typedef logic signed [9:0]  prod_t;
    typedef logic signed [11:0] sum_t;

    // 3x3 window: row 0 is two rows up, column 2 is the newest column
    typedef pix_t win_t [3][3];

    // One line store entry: two rows up and one row up at the same column
    typedef struct packed {
        pix_t upper;
        pix_t lower;
    } ls_t;

    // One result word
    typedef struct packed {
        pix_t   filtered;
        coord_t out_row;
        coord_t out_col;
        logic   run_last;
        logic   frame_done;
    } res_t;

    localparam int NUM_CAND = 4;

    // Control that travels with a set of candidate results
    typedef struct packed {
        logic [NUM_CAND-1:0] vld;
        logic                frame_end;
    } load_ctl_t;

    localparam int CFG_W = 11;
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_KERNEL_MODE  = 2'd0;
    localparam reg_idx_t REG_FRAME_WIDTH  = 2'd1;
    localparam reg_idx_t REG_FRAME_HEIGHT = 2'd2;

    localparam logic MODE_SOBEL   = 1'b0;
    localparam logic MODE_SHARPEN = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_SIZE_RST = 11'd1024;

    localparam coef_t KERN [2][3][3] = '{
        '{'{-4'sd1, 4'sd0, 4'sd1}, '{-4'sd2, 4'sd0, 4'sd2}, '{-4'sd1, 4'sd0, 4'sd1}},
        '{'{4'sd1, -4'sd2, 4'sd1}, '{-4'sd2, 4'sd5, 4'sd2}, '{4'sd1, -4'sd2, 4'sd1}}
    };

    localparam sum_t CLAMP_HI = 12'sd20;
    localparam sum_t CLAMP_LO = -12'sd20;

endpackage
`default_nettype wire

// ===== sv/clamped_3x3_image_convolution.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Streaming 3x3 convolution with zero padding and a clamp to -20..20. Feed
// signed pixels of one frame in raster order, one word per clock; the block
// keeps the two previous rows in a line store memory and a 3x3 window in
// registers, and returns result (r,c) once pixel (r+1,c+1) or the frame edge
// is reached. Most pixels yield at most one result word. Two kinds of pixel
// yield two: a pixel that closes a row below the first row, and every pixel
// of the last row after its first column. The last pixel of the frame yields
// up to four. The result buffer drains one word per clock while out_stall is
// low, so the input stalls after each pixel with more than one result. An
// accepted pixel passes through the stage 1, stage 2 window and result buffer
// registers before its first result word. Set kernel_mode, frame_width
// and frame_height only between frames, while no word is in flight. A width or
// height of zero counts as one; larger values saturate to MAX_WIDTH and
// MAX_HEIGHT. The line store holds no reset value and needs no clearing pass.
// Depends on c3c_pkg, c3c_line_store, c3c_conv and c3c_out_buf.
module clamped_3x3_image_convolution #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration write port
    input  wire logic                      cfg_we,
    input  wire c3c_pkg::reg_idx_t         cfg_index,
    input  wire logic [c3c_pkg::CFG_W-1:0] cfg_data,
    // pixel input
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire c3c_pkg::pix_t             pixel,
    // result output
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output c3c_pkg::pix_t                  filtered,
    output c3c_pkg::coord_t                out_row,
    output c3c_pkg::coord_t                out_col,
    output logic                           run_last,
    output logic                           frame_done
);
    import c3c_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // configuration registers
    logic             kernel_mode_reg;
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    // raster position of the next pixel
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    logic [CW:0]   w_eff;
    logic [RW:0]   h_eff;
    logic          lastc;
    logic          lastr;
    logic          accept;

    // stage 1: pixel held while its line store read is in flight
    logic          s1_vld_reg;
    logic          s1_vld_next;
    pix_t          s1_pix_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_lastc_reg;
    logic          s1_lastr_reg;
    logic          s1_adv;

    // stage 2: window holds the neighborhood of the latest pixel
    logic          s2_vld_reg;
    logic          s2_vld_next;
    logic [CW-1:0] s2_col_reg;
    logic [RW-1:0] s2_row_reg;
    logic          s2_lastc_reg;
    logic          s2_lastr_reg;
    win_t          win_reg;
    win_t          win_next;

    ls_t           ls_rd;
    ls_t           ls_wd;

    pix_t          conv_res [NUM_CAND];
    res_t          cand     [NUM_CAND];
    load_ctl_t     load_ctl;
    logic          load_rdy;
    res_t          head;

    logic          row_pos;
    logic          col_pos;
    coord_t        row_cur;
    coord_t        row_up;
    coord_t        col_cur;
    coord_t        col_left;

    // ------------------------------------------------------------------
    // Configuration: ignore writes to unused indexes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg  <= MODE_SOBEL;
            frame_width_reg  <= FRAME_SIZE_RST;
            frame_height_reg <= FRAME_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KERNEL_MODE:  kernel_mode_reg  <= cfg_data[0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective frame size: zero counts as one, saturate at the maximum
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = (CW+1)'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end
        else
        begin
            w_eff = (CW+1)'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            h_eff = (RW+1)'(1);
        end
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = (RW+1)'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = (RW+1)'(frame_height_reg);
        end
    end

    // A counter at or past the last column or row closes the row or frame
    assign lastc = (({1'b0, col_reg} + (CW+1)'(1)) >= w_eff);
    assign lastr = (({1'b0, row_reg} + (RW+1)'(1)) >= h_eff);

    // ------------------------------------------------------------------
    // Handshake: stage 1 advances when stage 2 is free or being drained
    // ------------------------------------------------------------------
    assign s1_adv   = s1_vld_reg && (!s2_vld_reg || load_rdy);
    assign in_stall = s1_vld_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (lastc)
            begin
                col_next = '0;
                row_next = lastr ? '0 : (row_reg + RW'(1));
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (accept)
        begin
            s1_vld_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_vld_next = 1'b0;
        end

        s2_vld_next = s2_vld_reg;
        if (s1_adv)
        begin
            s2_vld_next = 1'b1;
        end
        else if (load_rdy)
        begin
            s2_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    // Capture the pixel and its position on accept; pass the position to stage 2 on advance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_lastc_reg <= lastc;
            s1_lastr_reg <= lastr;
        end
        if (s1_adv)
        begin
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
            s2_lastc_reg <= s1_lastc_reg;
            s2_lastr_reg <= s1_lastr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line store: read the column on accept, push the rows down on advance
    // ------------------------------------------------------------------
    assign ls_wd.upper = ls_rd.lower;
    assign ls_wd.lower = s1_pix_reg;

    c3c_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk (clk),
        .re  (accept),
        .ra  (col_reg),
        .we  (s1_adv),
        .wa  (s1_col_reg),
        .wd  (ls_wd),
        .rd  (ls_rd)
    );

    // ------------------------------------------------------------------
    // Window: shift left, clear at the start of a row, load the new column
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = (s1_col_reg == '0) ? '0 : win_reg[i][1];
            win_next[i][1] = (s1_col_reg == '0) ? '0 : win_reg[i][2];
        end
        // rows above the frame count as zero
        win_next[0][2] = (32'(s1_row_reg) >= 32'd2) ? ls_rd.upper : '0;
        win_next[1][2] = (32'(s1_row_reg) >= 32'd1) ? ls_rd.lower : '0;
        win_next[2][2] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (s1_adv)
        begin
            win_reg <= win_next;
        end
    end

    // ------------------------------------------------------------------
    // Four candidate results: up-left, up, left and the current centre.
    // Shifting the view down or right drops the cells past the frame edge.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NUM_CAND; g++)
    begin : g_conv
        localparam logic RS = (g >= 2);
        localparam logic CS = ((g % 2) == 1);

        c3c_conv u_conv (
            .mode   (kernel_mode_reg),
            .rs     (RS),
            .cs     (CS),
            .win    (win_reg),
            .result (conv_res[g])
        );
    end

    assign row_pos  = (s2_row_reg != '0);
    assign col_pos  = (s2_col_reg != '0);
    assign row_cur  = 10'(s2_row_reg);
    assign row_up   = 10'(s2_row_reg - RW'(1));
    assign col_cur  = 10'(s2_col_reg);
    assign col_left = 10'(s2_col_reg - CW'(1));

    always_comb
    begin
        for (int g = 0; g < NUM_CAND; g++)
        begin
            cand[g].filtered   = conv_res[g];
            cand[g].out_row    = (g >= 2) ? row_cur : row_up;
            cand[g].out_col    = ((g % 2) == 1) ? col_cur : col_left;
            cand[g].run_last   = 1'b0;
            cand[g].frame_done = 1'b0;
        end
        // order: row above first, then the current row on the last row
        load_ctl.vld[0]   = row_pos && col_pos;
        load_ctl.vld[1]   = row_pos && s2_lastc_reg;
        load_ctl.vld[2]   = s2_lastr_reg && col_pos;
        load_ctl.vld[3]   = s2_lastr_reg && s2_lastc_reg;
        load_ctl.frame_end = s2_lastr_reg && s2_lastc_reg;
    end

    // ------------------------------------------------------------------
    // Result buffer: while out_stall is low, drain one word per clock
    // ------------------------------------------------------------------
    c3c_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_vld  (s2_vld_reg),
        .load_ctl  (load_ctl),
        .cand      (cand),
        .load_rdy  (load_rdy),
        .out_vld   (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign filtered   = head.filtered;
    assign out_row    = head.out_row;
    assign out_col    = head.out_col;
    assign run_last   = head.run_last;
    assign frame_done = head.frame_done;

endmodule
`default_nettype wire

// ===== sv/c3c_line_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Two line stores packed into one memory, one read and one write port.
// Depends on c3c_pkg for the entry type.
module c3c_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic            clk,
    input  wire logic            re,
    input  wire logic [AW-1:0]   ra,
    input  wire logic            we,
    input  wire logic [AW-1:0]   wa,
    input  wire c3c_pkg::ls_t    wd,
    output c3c_pkg::ls_t         rd
);
    import c3c_pkg::*;

    ls_t mem [DEPTH];
    ls_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        // forward a write to the same column in the same cycle
        if (re)
        begin
            rd_reg <= (we && (wa == ra)) ? wd : mem[ra];
        end
    end

    assign rd = rd_reg;

endmodule
`default_nettype wire

// ===== sv/c3c_conv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One clamped 3x3 convolution over a shifted view of the window.
// Depends on c3c_pkg for kernel tables, window type and clamp bounds.
module c3c_conv (
    input  wire logic         mode,
    input  wire logic         rs,
    input  wire logic         cs,
    input  wire c3c_pkg::win_t win,
    output c3c_pkg::pix_t     result
);
    import c3c_pkg::*;

    logic [1:0] ri;
    logic [1:0] cj;
    prod_t      prod;
    sum_t       sum;

    always_comb
    begin
        sum  = '0;
        ri   = '0;
        cj   = '0;
        prod = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ri = 2'(i) + {1'b0, rs};
                cj = 2'(j) + {1'b0, cs};
                // cells shifted past the window edge count as zero
                if ((ri <= 2'd2) && (cj <= 2'd2))
                begin
                    prod = KERN[mode][i][j] * win[ri][cj];
                    sum  = sum + 12'(prod);
                end
            end
        end
        if (sum > CLAMP_HI)
        begin
            result = 6'(CLAMP_HI);
        end
        else if (sum < CLAMP_LO)
        begin
            result = 6'(CLAMP_LO);
        end
        else
        begin
            result = sum[5:0];
        end
    end

endmodule
`default_nettype wire

// ===== sv/c3c_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result buffer: packs up to four results, drains one per cycle unless stalled.
// Depends on c3c_pkg for the result word and load control types.
module c3c_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load_vld,
    input  wire c3c_pkg::load_ctl_t load_ctl,
    input  wire c3c_pkg::res_t     cand [c3c_pkg::NUM_CAND],
    output logic                   load_rdy,
    output logic                   out_vld,
    input  wire logic              out_stall,
    output c3c_pkg::res_t          head
);
    import c3c_pkg::*;

    res_t       ent_reg  [NUM_CAND];
    res_t       ent_next [NUM_CAND];
    res_t       cmp      [NUM_CAND];
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [2:0] k;
    logic       take;

    assign out_vld  = (cnt_reg != 3'd0);
    assign take     = out_vld && !out_stall;
    assign load_rdy = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && take);
    assign head     = ent_reg[0];

    // pack the valid candidates in order, flag the last one
    always_comb
    begin
        k = 3'd0;
        for (int s = 0; s < NUM_CAND; s++)
        begin
            cmp[s] = '0;
        end
        for (int s = 0; s < NUM_CAND; s++)
        begin
            if (load_ctl.vld[s])
            begin
                cmp[k[1:0]] = cand[s];
                k = k + 3'd1;
            end
        end
        if (k != 3'd0)
        begin
            cmp[2'(k - 3'd1)].run_last   = 1'b1;
            cmp[2'(k - 3'd1)].frame_done = load_ctl.frame_end;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        for (int s = 0; s < NUM_CAND; s++)
        begin
            ent_next[s] = ent_reg[s];
        end
        if (load_vld && load_rdy)
        begin
            cnt_next = k;
            for (int s = 0; s < NUM_CAND; s++)
            begin
                ent_next[s] = cmp[s];
            end
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 3'd1;
            for (int s = 0; s < NUM_CAND - 1; s++)
            begin
                ent_next[s] = ent_reg[s+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NUM_CAND; s++)
        begin
            ent_reg[s] <= ent_next[s];
        end
    end

endmodule
`default_nettype wire
